[sv/mlfd_pkg.sv]
// Shared types and constants for the marker/length frame deframer.
package mlfd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LenWidth   = 15;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 15;

   // Register indexes on the configuration port
   localparam logic [CsrIdxWidth-1:0] REG_START_FIRST  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_START_SECOND = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_END_FIRST    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_END_SECOND   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_LENGTH   = 3'd4;

   // Register reset values
   localparam logic [ByteWidth-1:0] START_FIRST_RST  = 8'd170;
   localparam logic [ByteWidth-1:0] START_SECOND_RST = 8'd85;
   localparam logic [ByteWidth-1:0] END_FIRST_RST    = 8'd85;
   localparam logic [ByteWidth-1:0] END_SECOND_RST   = 8'd170;
   localparam logic [LenWidth-1:0]  MAX_LENGTH_RST   = 15'd2042;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_OK    = 2'd1,
      KIND_TRAIL = 2'd2,
      KIND_LEN   = 2'd3
   } kind_type;

   // Frame parser phases, one-hot
   typedef enum logic [7:0] {
      PH_HUNT1    = 8'b0000_0001,
      PH_HUNT2    = 8'b0000_0010,
      PH_LEN_LO   = 8'b0000_0100,
      PH_LEN_HI   = 8'b0000_1000,
      PH_PAYLOAD  = 8'b0001_0000,
      PH_END1     = 8'b0010_0000,
      PH_END2_OK  = 8'b0100_0000,
      PH_END2_BAD = 8'b1000_0000
   } phase_type;

   // Configuration seen by the parser
   typedef struct packed {
      logic [ByteWidth-1:0] start_first;
      logic [ByteWidth-1:0] start_second;
      logic [ByteWidth-1:0] end_first;
      logic [ByteWidth-1:0] end_second;
      logic [LenWidth-1:0]  max_length;
   } cfg_type;

   // Result of one parse step
   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [ByteWidth-1:0] data;
      logic [LenWidth-1:0]  length;
   } result_type;

endpackage

[sv/mlfd_if.sv]
// Valid/ready channel interfaces for received bytes and deframer results.
interface mlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic [14:0] out_length;

   modport source (output valid, output out_kind, output out_byte, output out_length,
                   input ready);
   modport sink   (input valid, input out_kind, input out_byte, input out_length,
                   output ready);
endinterface

[sv/marker_length_frame_deframer.sv]
// Top level of the marker/length frame deframer: input and result registers.
//
// req carries one received byte per item; rsp carries at most one result per
// byte: a payload byte (kind 0), frame accepted (1), bad end marker (2) or
// bad length (3). Hunt bytes, a good length field and the first trailer byte
// give no result. The csr_ port writes the marker bytes and the length limit,
// one register per cycle, and should only be used while the block is idle.
//
// An accepted byte is held in the input register, parsed by the state machine,
// and its result, if any, lands in the result register that drives rsp valid.
// One byte per cycle is sustained while no result waits on a stalled rsp; the
// input register refills in the same cycle it drains.
//
// When rsp is stalled, bytes that make no result still pass through; a byte
// that makes a result waits in the input register and req.ready drops.
// Synchronous reset empties both registers, restores the default markers
// (170,85 start / 85,170 end) and limit 2042, and restarts the marker hunt.
module marker_length_frame_deframer
   import mlfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   mlfd_req_if.sink                req,
   mlfd_rsp_if.source              rsp,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   cfg_type              cfg;
   result_type           result;
   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff;
   kind_type             out_kind_ff;
   logic [ByteWidth-1:0] out_byte_ff;
   logic [LenWidth-1:0]  out_length_ff;
   logic                 out_free;
   logic                 step;

   mlfd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   mlfd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Handshake: a held byte moves on unless its result has nowhere to go
   assign out_free  = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && (!result.valid || out_free);
   assign req.ready = !in_valid_ff || step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_kind_ff   <= result.kind;
         out_byte_ff   <= result.data;
         out_length_ff <= result.length;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_kind   = out_kind_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.out_length = out_length_ff;

endmodule

[sv/mlfd_csr.sv]
// Configuration registers: start/end marker bytes and payload length limit.
module mlfd_csr
   import mlfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_START_FIRST:  cfg_in.start_first  = csr_data[ByteWidth-1:0];
            REG_START_SECOND: cfg_in.start_second = csr_data[ByteWidth-1:0];
            REG_END_FIRST:    cfg_in.end_first    = csr_data[ByteWidth-1:0];
            REG_END_SECOND:   cfg_in.end_second   = csr_data[ByteWidth-1:0];
            REG_MAX_LENGTH:   cfg_in.max_length   = csr_data[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_first  <= START_FIRST_RST;
         cfg_ff.start_second <= START_SECOND_RST;
         cfg_ff.end_first    <= END_FIRST_RST;
         cfg_ff.end_second   <= END_SECOND_RST;
         cfg_ff.max_length   <= MAX_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/mlfd_parse.sv]
// Frame parser state machine: marker hunt, length field, payload count, trailer check.
module mlfd_parse
   import mlfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] rx_byte,
   input  cfg_type              cfg,
   output result_type           result
);

   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] length_low_ff, length_low_in;
   logic [LenWidth-1:0]  frame_length_ff, frame_length_in;
   logic [LenWidth-1:0]  bytes_left_ff, bytes_left_in;

   logic [LenWidth-1:0]  len_field;
   logic                 len_bad;

   // Length field: high byte arriving now, low byte held
   assign len_field = {rx_byte[ByteWidth-2:0], length_low_ff};
   assign len_bad   = rx_byte[ByteWidth-1] || (len_field > cfg.max_length);

   // Next state and result for the byte being processed
   always_comb begin
      phase_in        = phase_ff;
      length_low_in   = length_low_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      result          = '{valid: 1'b0, kind: KIND_DATA, data: '0, length: '0};
      unique case (phase_ff)
         PH_HUNT1: begin
            if (rx_byte == cfg.start_first) phase_in = PH_HUNT2;
         end
         PH_HUNT2: begin
            if (rx_byte == cfg.start_second) phase_in = PH_LEN_LO;
            else if (rx_byte == cfg.start_first) phase_in = PH_HUNT2;
            else phase_in = PH_HUNT1;
         end
         PH_LEN_LO: begin
            length_low_in = rx_byte;
            phase_in      = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (len_bad) begin
               phase_in     = PH_HUNT1;
               result.valid = 1'b1;
               result.kind  = KIND_LEN;
            end else begin
               frame_length_in = len_field;
               bytes_left_in   = len_field;
               phase_in        = (len_field == '0) ? PH_END1 : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in = bytes_left_ff - LenWidth'(1);
            if (bytes_left_ff == LenWidth'(1)) phase_in = PH_END1;
            result.valid = 1'b1;
            result.kind  = KIND_DATA;
            result.data  = rx_byte;
         end
         PH_END1: begin
            phase_in = (rx_byte == cfg.end_first) ? PH_END2_OK : PH_END2_BAD;
         end
         PH_END2_OK: begin
            phase_in      = PH_HUNT1;
            result.valid  = 1'b1;
            result.kind   = (rx_byte == cfg.end_second) ? KIND_OK : KIND_TRAIL;
            result.length = frame_length_ff;
         end
         PH_END2_BAD: begin
            phase_in      = PH_HUNT1;
            result.valid  = 1'b1;
            result.kind   = KIND_TRAIL;
            result.length = frame_length_ff;
         end
         default: begin
            phase_in = PH_HUNT1;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         bytes_left_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   // Frame fields
   always_ff @(posedge clock) begin
      if (step) begin
         length_low_ff   <= length_low_in;
         frame_length_ff <= frame_length_in;
      end
   end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the marker/length frame deframer: stream in, results out.
module tb_top;
   import mlfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // No register lives at this index; writes to it must be dropped
   localparam logic [CsrIdxWidth-1:0] REG_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 215;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT = 2000;

   // One deframer result as seen on rsp
   typedef struct packed {
      kind_type             kind;
      logic [ByteWidth-1:0] data;
      logic [LenWidth-1:0]  length;
   } frame_event_type;

   // Tracks the deframer state, predicts results and checks them in order
   class frame_scoreboard;
      logic [ByteWidth-1:0] start_first;
      logic [ByteWidth-1:0] start_second;
      logic [ByteWidth-1:0] end_first;
      logic [ByteWidth-1:0] end_second;
      logic [LenWidth-1:0]  max_len;
      phase_type            phase;
      logic [ByteWidth-1:0] len_low;
      logic [LenWidth-1:0]  frame_len;
      logic [LenWidth-1:0]  remaining;
      frame_event_type      expected_q[$];
      int                   errors;

      function new();
         start_first  = START_FIRST_RST;
         start_second = START_SECOND_RST;
         end_first    = END_FIRST_RST;
         end_second   = END_SECOND_RST;
         max_len      = MAX_LENGTH_RST;
         phase        = PH_HUNT1;
         len_low      = '0;
         frame_len    = '0;
         remaining    = '0;
         errors       = 0;
      endfunction

      function void write_register(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            REG_START_FIRST:  start_first  = value[ByteWidth-1:0];
            REG_START_SECOND: start_second = value[ByteWidth-1:0];
            REG_END_FIRST:    end_first    = value[ByteWidth-1:0];
            REG_END_SECOND:   end_second   = value[ByteWidth-1:0];
            REG_MAX_LENGTH:   max_len      = value[LenWidth-1:0];
            default: ;
         endcase
      endfunction

      function void push_result(kind_type kind, logic [ByteWidth-1:0] data,
                                logic [LenWidth-1:0] length);
         frame_event_type ev;
         ev.kind   = kind;
         ev.data   = data;
         ev.length = length;
         expected_q.push_back(ev);
      endfunction

      // Advance the parser by one accepted byte
      function void note_byte(logic [ByteWidth-1:0] rx);
         logic [15:0] len16;
         case (phase)
            PH_HUNT1: begin
               if (rx == start_first) phase = PH_HUNT2;
            end
            PH_HUNT2: begin
               // second start byte wins over a repeated first byte
               if (rx == start_second) phase = PH_LEN_LO;
               else if (rx == start_first) phase = PH_HUNT2;
               else phase = PH_HUNT1;
            end
            PH_LEN_LO: begin
               len_low = rx;
               phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len16 = {rx, len_low};
               if (len16[15] || len16[LenWidth-1:0] > max_len) begin
                  phase = PH_HUNT1;
                  push_result(KIND_LEN, '0, '0);
               end else begin
                  frame_len = len16[LenWidth-1:0];
                  remaining = frame_len;
                  if (frame_len == 0) phase = PH_END1;
                  else phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               remaining = remaining - 1'b1;
               if (remaining == 0) phase = PH_END1;
               push_result(KIND_DATA, rx, '0);
            end
            PH_END1: begin
               if (rx == end_first) phase = PH_END2_OK;
               else phase = PH_END2_BAD;
            end
            PH_END2_OK: begin
               phase = PH_HUNT1;
               if (rx == end_second) push_result(KIND_OK, '0, frame_len);
               else push_result(KIND_TRAIL, '0, frame_len);
            end
            default: begin
               // trailer already broken: second byte is swallowed
               phase = PH_HUNT1;
               push_result(KIND_TRAIL, '0, frame_len);
            end
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [ByteWidth-1:0] data,
                                 logic [LenWidth-1:0] length);
         frame_event_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: kind %0d byte %0d length %0d",
                     $time, kind, data, length);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (exp.kind !== kind) begin
            $display("%0t: out_kind mismatch: expected %0d, got %0d", $time, exp.kind, kind);
            errors++;
         end
         if (exp.data !== data) begin
            $display("%0t: out_byte mismatch: expected %0d, got %0d", $time, exp.data, data);
            errors++;
         end
         if (exp.length !== length) begin
            $display("%0t: out_length mismatch: expected %0d, got %0d",
                     $time, exp.length, length);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_en;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   mlfd_req_if req_ch();
   mlfd_rsp_if rsp_ch();

   frame_scoreboard board = new();
   int  items_sent = 0;
   int  quiet_cycles = 0;
   bit  no_gap_mode = 1'b0;

   marker_length_frame_deframer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check every result taken on rsp
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.out_kind, rsp_ch.out_byte, rsp_ch.out_length);
   end

   // Count cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   // Result side: random stalls, mostly short, with long stall-free stretches
   initial begin
      int run;
      int stall;
      int r;
      rsp_ch.ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         r = $urandom_range(0, 99);
         if (r < 50) stall = 0;
         else if (r < 90) stall = $urandom_range(1, 3);
         else stall = $urandom_range(10, 40);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gap_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one byte; returns at the edge where it is accepted
   task automatic push_byte(input logic [ByteWidth-1:0] value);
      int idle;
      idle = pick_gap();
      if (idle > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      board.note_byte(value);
      items_sent++;
   endtask

   // Hold off the sender until all results are back and the pipe is empty
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all registers, plus one write to an unused index
   task automatic apply_config(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [7:0] ef, input logic [7:0] es,
                               input logic [LenWidth-1:0] ml);
      logic [CsrIdxWidth-1:0]  idxs [6];
      logic [CsrDataWidth-1:0] vals [6];
      logic [6:0]              upper;
      upper = 7'($urandom_range(0, 127));
      idxs = '{REG_UNUSED, REG_START_FIRST, REG_START_SECOND, REG_END_FIRST,
               REG_END_SECOND, REG_MAX_LENGTH};
      vals = '{15'h5A5A, {upper, sf}, {~upper, ss}, {upper, ef}, {~upper, es}, ml};
      foreach (idxs[i]) begin
         csr_write_en <= 1'b1;
         csr_index    <= idxs[i];
         csr_data     <= vals[i];
         @(posedge clock);
         board.write_register(idxs[i], vals[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   // One mostly well-formed frame with random content, sometimes broken
   task automatic send_frame();
      logic [ByteWidth-1:0] frame_bytes[$];
      logic [15:0]          len16;
      int                   len;
      int                   cap;
      int                   r;
      bit                   len_ok;
      no_gap_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      // start marker
      r = $urandom_range(0, 9);
      frame_bytes.push_back(board.start_first);
      if (r == 0) frame_bytes.push_back(board.start_first);
      if (r == 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(board.start_second);
      // length field
      cap = (board.max_len < 24) ? board.max_len : 24;
      r = $urandom_range(0, 99);
      len_ok = 1'b1;
      if (r < 72) begin
         len = $urandom_range(0, cap);
         len16 = 16'(len);
      end else if (r < 82 && board.max_len <= 48) begin
         len = board.max_len;
         len16 = 16'(len);
      end else if (r < 91 && board.max_len < 32767) begin
         len_ok = 1'b0;
         if ($urandom_range(0, 1) == 0) len16 = 16'(board.max_len + $urandom_range(1, 2));
         else len16 = 16'($urandom_range(board.max_len + 1, 32767));
      end else begin
         len_ok = 1'b0;
         len16 = {1'b1, 15'($urandom_range(0, 32767))};
      end
      frame_bytes.push_back(len16[7:0]);
      frame_bytes.push_back(len16[15:8]);
      if (len_ok) begin
         repeat (len16) frame_bytes.push_back(8'($urandom_range(0, 255)));
         // end marker: good, bad first byte, or bad second byte
         r = $urandom_range(0, 9);
         if (r < 7) begin
            frame_bytes.push_back(board.end_first);
            frame_bytes.push_back(board.end_second);
         end else if (r == 7) begin
            frame_bytes.push_back(board.end_first ^ 8'($urandom_range(1, 255)));
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            frame_bytes.push_back(board.end_first);
            frame_bytes.push_back(board.end_second ^ 8'($urandom_range(1, 255)));
         end
      end
      foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
   endtask

   task automatic run_frames();
      int first;
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) send_frame();
   endtask

   initial begin
      logic [ByteWidth-1:0] directed[$];
      logic [7:0]           marker;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: junk then repeated first start byte and a one-byte frame,
      // broken start, negative length, length over the limit,
      // zero length with a bad first end byte
      directed = '{8'h00, START_FIRST_RST, START_FIRST_RST, START_SECOND_RST, 8'h01, 8'h00,
                   8'hFF, END_FIRST_RST, END_SECOND_RST,
                   START_FIRST_RST, 8'h00,
                   START_FIRST_RST, START_SECOND_RST, 8'hFF, 8'hFF,
                   START_FIRST_RST, START_SECOND_RST, 8'hFB, 8'h07,
                   START_FIRST_RST, START_SECOND_RST, 8'h00, 8'h00, 8'h00, END_SECOND_RST};
      foreach (directed[i]) push_byte(directed[i]);
      drain_results();

      // Reset settings, then the extremes, then random markers and limits
      run_frames();
      drain_results();
      apply_config(8'h00, 8'h00, 8'hFF, 8'hFF, 15'd0);
      run_frames();
      drain_results();
      apply_config(8'hFF, 8'hFF, 8'h00, 8'h00, 15'd32767);
      run_frames();
      drain_results();
      // identical start bytes: second-byte match must take priority
      marker = 8'($urandom_range(0, 255));
      apply_config(marker, marker, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   15'($urandom_range(0, 40)));
      run_frames();
      drain_results();
      apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   15'($urandom_range(0, 40)));
      run_frames();
      drain_results();

      if (board.errors == 0 && board.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
